// ===== sv/tmbs_pkg.sv =====
// Package for the tile map brush stamp block: opcodes, register indexes,
// store geometry and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package tmbs_pkg;

  localparam int MAP_DIM   = 128;
  localparam int BRUSH_DIM = 16;
  localparam int TILE_BITS = 16;

  localparam int MAP_AW      = $clog2(MAP_DIM);
  localparam int BRUSH_AW    = $clog2(BRUSH_DIM);
  localparam int MAP_CELLS   = MAP_DIM * MAP_DIM;
  localparam int BRUSH_CELLS = BRUSH_DIM * BRUSH_DIM;

  localparam int COORD_W = 16;
  localparam int VALUE_W = 16;
  localparam int SIZE_W  = 5;
  localparam int COUNT_W = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Width of the signed arithmetic used for clipping a stamp.
  localparam int CLIP_W = 18;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STAMP = 2'd1,
    OP_SET   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] MAP_WIDTH_RESET  = CFG_DATA_W'(128);
  localparam logic [CFG_DATA_W-1:0] MAP_HEIGHT_RESET = CFG_DATA_W'(128);

  typedef struct packed {
    logic latch;
    logic clear_we;
    logic brush_load;
    logic map_set;
    logic map_read;
    logic stamp_setup;
    logic walk;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic stamp_empty;
    logic stamp_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/tmbs_if.sv =====
// Handshake interfaces of the tile map brush stamp block: input items,
// result items and configuration writes. Depends on tmbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tmbs_item_if;
  import tmbs_pkg::*;

  logic                      valid;
  logic                      ready;
  op_e                       opcode;
  logic signed [COORD_W-1:0] col;
  logic signed [COORD_W-1:0] row;
  logic [VALUE_W-1:0]        tile_value;
  logic [SIZE_W-1:0]         brush_cols;
  logic [SIZE_W-1:0]         brush_rows;
  logic                      opaque;

  modport source (
    output valid, opcode, col, row, tile_value, brush_cols, brush_rows, opaque,
    input  ready
  );
  modport sink (
    input  valid, opcode, col, row, tile_value, brush_cols, brush_rows, opaque,
    output ready
  );
endinterface

interface tmbs_result_if;
  import tmbs_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0] cells_written;

  modport source (output valid, read_value, cells_written, input ready);
  modport sink   (input valid, read_value, cells_written, output ready);
endinterface

interface tmbs_cfg_if;
  import tmbs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/tmbs_ctrl.sv =====
// Controller of the tile map brush stamp block: sequences the clearing pass,
// each opcode and the result register handshake. Depends on tmbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmbs_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  input  tmbs_pkg::op_e          in_opcode_i,
  output logic                   in_ready_o,
  output logic                   res_valid_o,
  input  wire                    res_ready_i,
  output tmbs_pkg::ctrl_cmd_t    cmd_o,
  input  tmbs_pkg::dp_status_t   status_i
);
  import tmbs_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SET,
    S_READ,
    S_SETUP,
    S_WALK,
    S_DRAIN_DONE
  } state_e;

  state_e state_q;
  logic   res_valid_q;
  logic   finish_q;
  logic   res_free;

  assign res_free    = !res_valid_q || res_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && !finish_q;
  assign res_valid_o = res_valid_q;

  // finish_q marks the cycle(s) in which an item waits for the result register.
  always_comb begin
    cmd_o             = '0;
    cmd_o.latch       = in_ready_o && in_valid_i;
    cmd_o.clear_we    = (state_q == S_CLEAR);
    cmd_o.brush_load  = (state_q == S_LOAD);
    cmd_o.map_set     = (state_q == S_SET);
    cmd_o.map_read    = (state_q == S_READ);
    cmd_o.stamp_setup = (state_q == S_SETUP);
    cmd_o.walk        = (state_q == S_WALK) && !status_i.stamp_empty;
    cmd_o.res_load    = finish_q && res_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      res_valid_q <= 1'b0;
      finish_q    <= 1'b0;
    end else begin
      if (cmd_o.res_load) begin
        res_valid_q <= 1'b1;
        finish_q    <= 1'b0;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_o.latch) begin
            case (in_opcode_i)
              OP_LOAD:  state_q <= S_LOAD;
              OP_SET:   state_q <= S_SET;
              OP_READ:  state_q <= S_READ;
              OP_STAMP: state_q <= S_SETUP;
              default:  state_q <= S_LOAD;
            endcase
          end
        end
        S_LOAD, S_SET, S_READ: begin
          finish_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_SETUP: begin
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (status_i.stamp_empty) begin
            finish_q <= 1'b1;
            state_q  <= S_IDLE;
          end else if (status_i.stamp_last) begin
            state_q <= S_DRAIN_DONE;
          end
        end
        S_DRAIN_DONE: begin
          // The last brush cell is written to the map in this cycle.
          finish_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tmbs_dpath.sv =====
// Datapath of the tile map brush stamp block: map and brush memories,
// configuration registers, stamp clipping, the brush walk and the result register.
// Depends on tmbs_pkg; driven by commands from tmbs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tmbs_dpath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  tmbs_pkg::ctrl_cmd_t                   cmd_i,
  output tmbs_pkg::dp_status_t                  status_o,
  input  wire signed [tmbs_pkg::COORD_W-1:0]    col_i,
  input  wire signed [tmbs_pkg::COORD_W-1:0]    row_i,
  input  wire [tmbs_pkg::VALUE_W-1:0]           tile_value_i,
  input  wire [tmbs_pkg::SIZE_W-1:0]            brush_cols_i,
  input  wire [tmbs_pkg::SIZE_W-1:0]            brush_rows_i,
  input  wire                                   opaque_i,
  input  tmbs_pkg::op_e                         opcode_i,
  input  wire                                   cfg_valid_i,
  input  wire [tmbs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [tmbs_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic [tmbs_pkg::VALUE_W-1:0]          read_value_o,
  output logic [tmbs_pkg::COUNT_W-1:0]          cells_written_o
);
  import tmbs_pkg::*;

  localparam int MAP_IW = 2 * MAP_AW;
  localparam int BR_IW  = 2 * BRUSH_AW;

  // Memories.
  logic [TILE_BITS-1:0] map_mem   [MAP_CELLS];
  logic [TILE_BITS-1:0] brush_mem [BRUSH_CELLS];

  // Configuration.
  logic [CFG_DATA_W-1:0] map_width_q, map_height_q;

  // Latched item.
  op_e                       op_q;
  logic signed [COORD_W-1:0] col_q, row_q;
  logic [TILE_BITS-1:0]      tile_q;
  logic [SIZE_W-1:0]         bcols_q, brows_q;
  logic                      opaque_q;

  // Clearing pass.
  logic [MAP_IW-1:0] clr_addr_q;

  // Stamp walk.
  logic [BRUSH_AW-1:0] x_q, y_q, x_first_q, x_end_q, y_end_q;
  logic                empty_q;
  logic                pipe_v_q;
  logic [MAP_IW-1:0]   pipe_addr_q;
  logic [TILE_BITS-1:0] brush_rd_q;

  // Read and count.
  logic [TILE_BITS-1:0] map_rd_q;
  logic                 rd_inside_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [VALUE_W-1:0]   res_value_q;
  logic [COUNT_W-1:0]   res_count_q;

  // Clipping arithmetic.
  logic signed [CLIP_W-1:0] col_s, row_s, mw_s, mh_s, bc_s, br_s;
  logic signed [CLIP_W-1:0] x0_s, y0_s, lim_x, lim_y, x1_s, y1_s, x1m_s, y1m_s;
  logic                     empty_c, map_hit, brush_in;

  logic                 pipe_we;
  logic                 map_we;
  logic [MAP_IW-1:0]    map_waddr;
  logic [TILE_BITS-1:0] map_wdata;
  logic [MAP_AW-1:0]    walk_row, walk_col;

  always_comb begin
    col_s = CLIP_W'(col_q);
    row_s = CLIP_W'(row_q);
    mw_s  = (CLIP_W'(map_width_q) > CLIP_W'(MAP_DIM)) ? CLIP_W'(MAP_DIM)
                                                       : CLIP_W'(map_width_q);
    mh_s  = (CLIP_W'(map_height_q) > CLIP_W'(MAP_DIM)) ? CLIP_W'(MAP_DIM)
                                                        : CLIP_W'(map_height_q);
    bc_s  = (CLIP_W'(bcols_q) > CLIP_W'(BRUSH_DIM)) ? CLIP_W'(BRUSH_DIM)
                                                     : CLIP_W'(bcols_q);
    br_s  = (CLIP_W'(brows_q) > CLIP_W'(BRUSH_DIM)) ? CLIP_W'(BRUSH_DIM)
                                                     : CLIP_W'(brows_q);
    x0_s  = (col_s < 0) ? -col_s : '0;
    y0_s  = (row_s < 0) ? -row_s : '0;
    lim_x = mw_s - col_s;
    lim_y = mh_s - row_s;
    x1_s  = (lim_x < bc_s) ? lim_x : bc_s;
    y1_s  = (lim_y < br_s) ? lim_y : br_s;
    x1m_s = x1_s - CLIP_W'(1);
    y1m_s = y1_s - CLIP_W'(1);
    empty_c  = (x0_s >= x1_s) || (y0_s >= y1_s);
    map_hit  = (col_s >= 0) && (col_s < mw_s) && (row_s >= 0) && (row_s < mh_s);
    brush_in = (col_s >= 0) && (col_s < BRUSH_DIM) && (row_s >= 0) && (row_s < BRUSH_DIM);
  end

  assign walk_row = row_q[MAP_AW-1:0] + MAP_AW'(y_q);
  assign walk_col = col_q[MAP_AW-1:0] + MAP_AW'(x_q);

  // A walked brush cell lands in the map unless it is empty on a see-through brush.
  assign pipe_we = pipe_v_q && (opaque_q || (brush_rd_q != '0));

  always_comb begin
    map_we    = 1'b0;
    map_waddr = pipe_addr_q;
    map_wdata = brush_rd_q;
    if (cmd_i.clear_we) begin
      map_we    = 1'b1;
      map_waddr = clr_addr_q;
      map_wdata = '0;
    end else if (pipe_we) begin
      map_we = 1'b1;
    end else if (cmd_i.map_set && map_hit) begin
      map_we    = 1'b1;
      map_waddr = {row_q[MAP_AW-1:0], col_q[MAP_AW-1:0]};
      map_wdata = tile_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (cmd_i.map_read) begin
      map_rd_q <= map_mem[{row_q[MAP_AW-1:0], col_q[MAP_AW-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.brush_load && brush_in) begin
      brush_mem[{row_q[BRUSH_AW-1:0], col_q[BRUSH_AW-1:0]}] <= tile_q;
    end
    if (cmd_i.walk) begin
      brush_rd_q <= brush_mem[BR_IW'({y_q, x_q})];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RESET;
      map_height_q <= MAP_HEIGHT_RESET;
      clr_addr_q   <= '0;
      pipe_v_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == CFG_MAP_WIDTH)) begin
        map_width_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == CFG_MAP_HEIGHT)) begin
        map_height_q <= cfg_data_i;
      end
      if (cmd_i.clear_we) begin
        clr_addr_q <= clr_addr_q + MAP_IW'(1);
      end
      pipe_v_q <= cmd_i.walk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= opcode_i;
      col_q    <= col_i;
      row_q    <= row_i;
      tile_q   <= TILE_BITS'(tile_value_i);
      bcols_q  <= brush_cols_i;
      brows_q  <= brush_rows_i;
      opaque_q <= opaque_i;
      cnt_q    <= '0;
    end else if (pipe_we || (cmd_i.map_set && map_hit)) begin
      cnt_q <= cnt_q + COUNT_W'(1);
    end
    if (cmd_i.map_read) begin
      rd_inside_q <= map_hit;
    end
    if (cmd_i.stamp_setup) begin
      empty_q   <= empty_c;
      x_first_q <= x0_s[BRUSH_AW-1:0];
      x_q       <= x0_s[BRUSH_AW-1:0];
      y_q       <= y0_s[BRUSH_AW-1:0];
      x_end_q   <= x1m_s[BRUSH_AW-1:0];
      y_end_q   <= y1m_s[BRUSH_AW-1:0];
    end else if (cmd_i.walk) begin
      if (x_q == x_end_q) begin
        x_q <= x_first_q;
        y_q <= y_q + BRUSH_AW'(1);
      end else begin
        x_q <= x_q + BRUSH_AW'(1);
      end
    end
    if (cmd_i.walk) begin
      pipe_addr_q <= {walk_row, walk_col};
    end
    if (cmd_i.res_load) begin
      res_value_q <= ((op_q == OP_READ) && rd_inside_q) ? VALUE_W'(map_rd_q) : '0;
      res_count_q <= cnt_q;
    end
  end

  assign status_o.clear_last  = (clr_addr_q == {MAP_IW{1'b1}});
  assign status_o.stamp_empty = empty_q;
  assign status_o.stamp_last  = (x_q == x_end_q) && (y_q == y_end_q);

  assign read_value_o    = res_value_q;
  assign cells_written_o = res_count_q;

endmodule

`default_nettype wire

// ===== sv/tile_map_brush_stamp.sv =====
// Top level of the tile map brush stamp block: joins the controller and the
// datapath to the item, result and configuration channels. Depends on tmbs_pkg,
// tmbs_if, tmbs_ctrl and tmbs_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Tile map brush stamp. After reset the block clears its 128 x 128 tile map, one
// cell per clock, and takes no item until the clearing pass ends; configuration writes
// are taken at any time. Each item gives exactly one result item. A brush load,
// map set or map read passes through its own state and then loads the result
// register. A stamp passes through a setup state, then walks the brush cells left
// after clipping (at most 256) and loads the result once the last cell is written:
// the walk reads one brush cell and writes at most one map cell per cycle, bounded
// by the single write port of the map memory. The next item is taken only once the
// result of the last one is in the result register, which lets the next item be
// accepted while a result still waits.
module tile_map_brush_stamp (
  input  wire             clk_i,
  input  wire             rst_ni,
  tmbs_item_if.sink       item_i,
  tmbs_result_if.source   result_o,
  tmbs_cfg_if.sink        cfg_i
);
  import tmbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  tmbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_opcode_i (item_i.opcode),
    .in_ready_o  (item_i.ready),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tmbs_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .col_i           (item_i.col),
    .row_i           (item_i.row),
    .tile_value_i    (item_i.tile_value),
    .brush_cols_i    (item_i.brush_cols),
    .brush_rows_i    (item_i.brush_rows),
    .opaque_i        (item_i.opaque),
    .opcode_i        (item_i.opcode),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .read_value_o    (result_o.read_value),
    .cells_written_o (result_o.cells_written)
  );

endmodule

`default_nettype wire

// ===== test/tmbs_checker.sv =====
// Scoreboard for the tile map brush stamp block: keeps its own copy of the map,
// the brush and the size registers, predicts each result item and compares it.
// Depends on tmbs_pkg and the channel interfaces in tmbs_if.
`timescale 1ns / 1ps

module tmbs_checker
  import tmbs_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  tmbs_item_if   item_mon,
  tmbs_result_if result_mon,
  tmbs_cfg_if    cfg_mon,
  output int     fail_count_o,
  output int     pending_o
);

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] cells_written;
  } tile_result_t;

  logic [VALUE_W-1:0]    map_mem   [MAP_CELLS];
  logic [VALUE_W-1:0]    brush_mem [BRUSH_CELLS];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  tile_result_t          expected_q [$];

  function automatic int clamp_to(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic apply_command(input op_e op, input int c, input int r,
                               input logic [VALUE_W-1:0] val, input int bcols,
                               input int brows, input logic opq,
                               output tile_result_t res);
    int mw, mh, bw, bh, x0, y0, x1, y1, x, y, n;
    logic [VALUE_W-1:0] b;
    mw  = clamp_to(int'(width_reg), MAP_DIM);
    mh  = clamp_to(int'(height_reg), MAP_DIM);
    bw  = clamp_to(bcols, BRUSH_DIM);
    bh  = clamp_to(brows, BRUSH_DIM);
    res = '0;
    n   = 0;
    case (op)
      OP_LOAD: begin
        if (c >= 0 && c < BRUSH_DIM && r >= 0 && r < BRUSH_DIM) begin
          brush_mem[r * BRUSH_DIM + c] = val;
        end
      end
      OP_STAMP: begin
        // Clip the brush window against the left/top edge and the map size.
        x0 = (c < 0) ? -c : 0;
        y0 = (r < 0) ? -r : 0;
        x1 = (mw - c < bw) ? mw - c : bw;
        y1 = (mh - r < bh) ? mh - r : bh;
        for (y = y0; y < y1; y++) begin
          for (x = x0; x < x1; x++) begin
            b = brush_mem[y * BRUSH_DIM + x];
            // A zero brush cell is transparent unless the stamp is opaque.
            if (opq || b != '0) begin
              map_mem[(r + y) * MAP_DIM + (c + x)] = b;
              n++;
            end
          end
        end
        res.cells_written = COUNT_W'(clamp_to(n, 511));
      end
      OP_SET: begin
        if (c >= 0 && c < mw && r >= 0 && r < mh) begin
          map_mem[r * MAP_DIM + c] = val;
          res.cells_written = COUNT_W'(1);
        end
      end
      default: begin
        if (c >= 0 && c < mw && r >= 0 && r < mh) begin
          res.read_value = map_mem[r * MAP_DIM + c];
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tile_result_t want;
    tile_result_t got;
    if (!rst_ni) begin
      foreach (map_mem[i]) map_mem[i] = '0;
      width_reg    = MAP_WIDTH_RESET;
      height_reg   = MAP_HEIGHT_RESET;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MAP_WIDTH:  width_reg = cfg_mon.data;
          CFG_MAP_HEIGHT: height_reg = cfg_mon.data;
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        got.read_value    = result_mon.read_value;
        got.cells_written = result_mon.cells_written;
        if (expected_q.size() == 0) begin
          $error("result item with no expectation waiting: read_value %0h cells_written %0d",
                 got.read_value, got.cells_written);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0h, actual %0h",
                   want.read_value, got.read_value);
            fail_count_o++;
          end
          if (got.cells_written !== want.cells_written) begin
            $error("cells_written mismatch: expected %0d, actual %0d",
                   want.cells_written, got.cells_written);
            fail_count_o++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        apply_command(item_mon.opcode, int'(item_mon.col), int'(item_mon.row),
                      item_mon.tile_value, int'(item_mon.brush_cols),
                      int'(item_mon.brush_rows), item_mon.opaque, want);
        expected_q.push_back(want);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the tile map brush stamp testbench: clock, reset, stimulus on the item
// and configuration channels, result back-pressure and the verdict.
// Depends on tmbs_pkg, tmbs_if, the block itself and tmbs_checker.
`timescale 1ns / 1ps

module tb_top;
  import tmbs_pkg::*;

  localparam int      HALF_PERIOD     = 6;
  localparam int      PHASES          = 7;
  localparam int      ITEMS_PER_PHASE = 145;
  localparam longint  RUN_LIMIT_NS    = 64'd60_000_000;

  typedef struct packed {
    op_e                       opcode;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic [VALUE_W-1:0]        tile_value;
    logic [SIZE_W-1:0]         brush_cols;
    logic [SIZE_W-1:0]         brush_rows;
    logic                      opaque;
  } tile_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   span_w = MAP_DIM;
  int   span_h = MAP_DIM;

  tmbs_item_if   item_ch ();
  tmbs_result_if result_ch ();
  tmbs_cfg_if    cfg_ch ();

  tile_map_brush_stamp u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  tmbs_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_ch),
    .result_mon   (result_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic tile_cmd_t make_cmd(op_e op, int c, int r, int val, int bc, int br,
                                         int opq);
    tile_cmd_t cmd;
    cmd.opcode     = op;
    cmd.col        = COORD_W'(c);
    cmd.row        = COORD_W'(r);
    cmd.tile_value = VALUE_W'(val);
    cmd.brush_cols = SIZE_W'(bc);
    cmd.brush_rows = SIZE_W'(br);
    cmd.opaque     = opq[0];
    return cmd;
  endfunction

  function automatic int rand_tile(int zero_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < zero_pct) return 0;
    if (pick < zero_pct + 8) return 16'hFFFF;
    return int'($urandom_range(16'hFFFF));
  endfunction

  // Mostly near the map so that edges get clipped, now and then anywhere.
  function automatic int rand_coord(int span);
    logic [COORD_W-1:0] raw;
    raw = COORD_W'($urandom);
    if ($urandom_range(99) < 6) return int'($signed(raw));
    return int'($urandom_range(span + 19)) - 18;
  endfunction

  function automatic int rand_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 30) return int'($urandom_range(31, 17));
    return int'($urandom_range(16, 1));
  endfunction

  function automatic tile_cmd_t random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      if ($urandom_range(9) < 8) begin
        return make_cmd(OP_LOAD, $urandom_range(BRUSH_DIM - 1), $urandom_range(BRUSH_DIM - 1),
                        rand_tile(30), rand_size(), rand_size(), $urandom_range(1));
      end
      return make_cmd(OP_LOAD, rand_coord(BRUSH_DIM), rand_coord(BRUSH_DIM), rand_tile(30),
                      rand_size(), rand_size(), $urandom_range(1));
    end
    if (pick < 40) begin
      return make_cmd(OP_STAMP, rand_coord(span_w), rand_coord(span_h), rand_tile(10),
                      rand_size(), rand_size(), $urandom_range(1));
    end
    if (pick < 65) begin
      return make_cmd(OP_SET, rand_coord(span_w), rand_coord(span_h), rand_tile(15),
                      rand_size(), rand_size(), $urandom_range(1));
    end
    return make_cmd(OP_READ, rand_coord(span_w), rand_coord(span_h), rand_tile(10),
                    rand_size(), rand_size(), $urandom_range(1));
  endfunction

  // Entered just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high.
  task automatic send_item(input tile_cmd_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= cmd.opcode;
    item_ch.col        <= cmd.col;
    item_ch.row        <= cmd.row;
    item_ch.tile_value <= cmd.tile_value;
    item_ch.brush_cols <= cmd.brush_cols;
    item_ch.brush_rows <= cmd.brush_rows;
    item_ch.opaque     <= cmd.opaque;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    int i;
    int phase;
    int w;
    int h;
    rst_ni             = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.opcode     = OP_LOAD;
    item_ch.col        = '0;
    item_ch.row        = '0;
    item_ch.tile_value = '0;
    item_ch.brush_cols = '0;
    item_ch.brush_rows = '0;
    item_ch.opaque     = 1'b0;
    result_ch.ready    = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_MAP_WIDTH;
    cfg_ch.data        = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill the whole brush first so that no stamp ever reads an unloaded cell.
    for (i = 0; i < BRUSH_CELLS; i++) begin
      send_item(make_cmd(OP_LOAD, i % BRUSH_DIM, i / BRUSH_DIM, rand_tile(30), 0, 0, 0));
    end

    // Directed items at the reset map size.
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_SET, 0, 0, 16'hFFFF, 0, 0, 0));
    send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0));
    send_item(make_cmd(OP_SET, 127, 127, 1, 0, 0, 0));
    send_item(make_cmd(OP_READ, 127, 127, 0, 0, 0, 0));
    send_item(make_cmd(OP_SET, 128, 5, 16'h1234, 0, 0, 0));
    send_item(make_cmd(OP_SET, -1, 0, 16'h4321, 0, 0, 0));
    send_item(make_cmd(OP_READ, -32768, 32767, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 5, 128, 0, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, -1, 3, 16'hAAAA, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 16, 0, 16'h5555, 0, 0, 0));
    send_item(make_cmd(OP_LOAD, 0, -32768, 16'h7777, 0, 0, 0));
    send_item(make_cmd(OP_STAMP, -32768, -32768, 0, 16, 16, 1));
    send_item(make_cmd(OP_STAMP, 0, 0, 0, 0, 5, 1));
    send_item(make_cmd(OP_STAMP, 10, 10, 0, 16, 16, 1));
    send_item(make_cmd(OP_STAMP, 40, 40, 0, 16, 16, 0));
    send_item(make_cmd(OP_STAMP, 120, 121, 0, 31, 31, 1));
    send_item(make_cmd(OP_STAMP, -5, -3, 0, 16, 16, 0));
    send_item(make_cmd(OP_READ, 127, 127, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 12, 11, 0, 0, 0, 0));
    send_item(make_cmd(OP_SET, 3, 3, 0, 0, 0, 0));
    send_item(make_cmd(OP_READ, 3, 3, 0, 0, 0, 0));
    send_item(make_cmd(OP_STAMP, 32767, 32767, 0, 16, 16, 1));
    send_item(make_cmd(OP_LOAD, 15, 15, 0, 0, 0, 0));
    send_item(make_cmd(OP_STAMP, 112, 112, 0, 16, 16, 1));

    for (phase = 0; phase < PHASES; phase++) begin
      // The sender holds off here until every outstanding result has come back.
      item_ch.valid <= 1'b0;
      wait_drained();
      case (phase)
        0: begin w = 128; h = 128; end
        1: begin w = 1;   h = 1;   end
        2: begin w = 255; h = 255; end
        3: begin w = 0;   h = 77;  end
        4: begin w = 37;  h = 0;   end
        5: begin w = 2;   h = 128; end
        default: begin
          w = $urandom_range(255);
          h = $urandom_range(255);
        end
      endcase
      write_reg(CFG_MAP_WIDTH, w);
      write_reg(CFG_MAP_HEIGHT, h);
      span_w = (w == 0) ? 4 : ((w > MAP_DIM) ? MAP_DIM : w);
      span_h = (h == 0) ? 4 : ((h > MAP_DIM) ? MAP_DIM : h);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 72; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_item(random_item());
      end
    end

    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    // Long enough for a full stamp, so a stray late result would still be caught.
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
